/* hdl/lbfc_pkg.sv */
// lbfc_pkg: shared constants for the load based frequency cap block
// field widths, register indexes and register reset values
// no dependencies
`default_nettype none

package lbfc_pkg;

   // field widths
   localparam int CORE_W   = 2;
   localparam int TIME_W   = 64;
   localparam int DELTA_W  = 32;
   localparam int LOAD_W   = 7;
   localparam int FREQ_W   = 22;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 22;
   localparam int RSP_DATA_W = 32;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE    = 2'd0,
      CSR_THRESHOLD = 2'd1,
      CSR_CAP_FREQ  = 2'd2
   } csr_index_type;

   // register reset values
   localparam logic [LOAD_W-1:0] THRESHOLD_RESET = 7'd90;
   localparam logic [FREQ_W-1:0] CAP_FREQ_RESET  = 22'd1300000;

   // previous counter pair kept per core (only the low halves matter)
   typedef struct packed {
      logic [DELTA_W-1:0] elapsed;
      logic [DELTA_W-1:0] idle;
   } hist_word_type;

endpackage

`default_nettype wire

/* hdl/lbfc_hist.sv */
// lbfc_hist: per-core store of the previous idle and elapsed counter low halves
// one write and one registered read per cycle, valid bit per entry
// depends on lbfc_pkg
`default_nettype none

module lbfc_hist #(
   parameter int NUM_CORES = 4,
   parameter int AW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         addr,
   input  wire lbfc_pkg::hist_word_type wr_data,
   output lbfc_pkg::hist_word_type    rd_data
);

   lbfc_pkg::hist_word_type mem_ff [NUM_CORES];
   lbfc_pkg::hist_word_type rd_word_ff;
   logic [NUM_CORES-1:0]    valid_ff;
   logic                    rd_valid_ff;

   // memory write and read-before-write registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_word_ff <= mem_ff[addr];
   end

   // entries read as zero until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[addr];
         if (wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

/* hdl/lbfc_div.sv */
// lbfc_div: bit-serial restoring divider for 100*busy/elapsed
// one quotient bit per cycle, into a LOAD_W-bit quotient
// depends on lbfc_pkg
`default_nettype none

module lbfc_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [lbfc_pkg::DELTA_W-1:0]     busy,
   input  wire logic [lbfc_pkg::DELTA_W-1:0]     divisor,
   output logic                                  done,
   output logic [lbfc_pkg::LOAD_W-1:0]           quotient
);

   localparam int REM_W = lbfc_pkg::DELTA_W + lbfc_pkg::LOAD_W;
   localparam int CNT_W = $clog2(lbfc_pkg::LOAD_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(lbfc_pkg::LOAD_W - 1);

   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [REM_W-1:0]            dvs_ff, dvs_in;
   logic [lbfc_pkg::LOAD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [REM_W-1:0]            scaled;
   logic                        fits;

   // dividend = busy * 100 = busy*64 + busy*32 + busy*4
   assign scaled = {1'b0, busy, 6'd0} + {2'd0, busy, 5'd0} + {5'd0, busy, 2'd0};
   assign fits   = (rem_ff >= dvs_ff);

   // one restoring step per cycle, divisor walks down one bit at a time
   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = scaled;
         dvs_in = {1'b0, divisor, 6'd0};
         quo_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (fits) begin
            rem_in = rem_ff - dvs_ff;
         end
         quo_in = {quo_ff[lbfc_pkg::LOAD_W-2:0], fits};
         dvs_in = {1'b0, dvs_ff[REM_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* hdl/load_based_frequency_cap_core.sv */
// load_based_frequency_cap_core: top level of the load based frequency cap
// instantiates lbfc_hist and lbfc_div, uses lbfc_pkg
`default_nettype none

// Each request carries one core's cumulative idle and elapsed counters; the
// block takes 32-bit deltas against the stored previous pair, computes the
// load 100*busy/elapsed with a bit-serial divider (one quotient bit per
// cycle) and tracks the round peak. A request with tlast closes the round and
// yields one response with the peak, the cap decision, whether it changed
// and the ceiling. Requests are taken one at a time: an enabled request holds
// the input through the read of the history store, two delta stages, the
// seven-step divider and the peak update; a round-closing request adds the
// finish step plus any wait for the response register to drain. While
// disabled a request is taken and dropped. Core indexes at or above
// NUM_CORES contribute no load but tlast still closes the round.
module load_based_frequency_cap_core #(
   parameter int NUM_CORES = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // request channel
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,   // idle_time [63:0], elapsed_time [127:64]
   input  wire logic [1:0]    req_tuser,   // core_index [1:0]
   input  wire logic          req_tlast,   // last_core
   // response channel
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata,   // peak_load [6:0], cap_active [7],
                                           // cap_changed [8], ceiling_khz [30:9], zero [31]
   // configuration
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_index,
   input  wire logic [21:0]   csr_wdata
);

   localparam int AW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam int DW = lbfc_pkg::DELTA_W;
   localparam int LW = lbfc_pkg::LOAD_W;
   localparam int FW = lbfc_pkg::FREQ_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DELTA,
      ST_DIVGO,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [DW-1:0]           cur_idle_ff, cur_idle_in;
   logic [DW-1:0]           cur_el_ff, cur_el_in;
   logic                    last_ff, last_in;
   logic [DW-1:0]           d_idle_ff, d_idle_in;
   logic [DW-1:0]           d_el_ff, d_el_in;
   logic [DW-1:0]           busy_ff, busy_in;
   logic                    dzero_ff, dzero_in;
   logic [LW-1:0]           round_max_ff, round_max_in;
   logic                    limit_ff, limit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]           rsp_peak_ff, rsp_peak_in;
   logic                    rsp_cap_ff, rsp_cap_in;
   logic                    rsp_chg_ff, rsp_chg_in;
   logic [FW-1:0]           rsp_ceil_ff, rsp_ceil_in;
   logic                    enable_ff;
   logic [LW-1:0]           threshold_ff;
   logic [FW-1:0]           cap_freq_ff;

   logic                    req_accept;
   logic                    core_valid;
   logic                    hist_wr;
   logic [AW-1:0]           hist_addr;
   lbfc_pkg::hist_word_type hist_wdata;
   lbfc_pkg::hist_word_type hist_rdata;
   logic                    div_start;
   logic                    div_done;
   logic [LW-1:0]           div_quo;
   logic [LW-1:0]           core_load;
   logic [DW:0]             busy_diff;
   logic                    new_limit;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign core_valid = (32'(req_tuser) < 32'(NUM_CORES));

   // history store write happens at accept, read of the old pair at the same edge
   assign hist_wr            = req_accept && enable_ff && core_valid;
   assign hist_addr          = AW'(req_tuser);
   assign hist_wdata.idle    = req_tdata[DW-1:0];
   assign hist_wdata.elapsed = req_tdata[lbfc_pkg::TIME_W+DW-1:lbfc_pkg::TIME_W];

   lbfc_hist #(
      .NUM_CORES (NUM_CORES),
      .AW        (AW)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (hist_wr),
      .addr    (hist_addr),
      .wr_data (hist_wdata),
      .rd_data (hist_rdata)
   );

   assign div_start = (state_ff == ST_DIVGO);

   lbfc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .busy     (busy_ff),
      .divisor  (d_el_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // busy clamps to zero when idle delta reaches elapsed delta
   assign busy_diff = {1'b0, d_el_ff} - {1'b0, d_idle_ff};
   assign core_load = dzero_ff ? '0 : div_quo;
   assign new_limit = (round_max_ff <= threshold_ff);

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      cur_idle_in  = cur_idle_ff;
      cur_el_in    = cur_el_ff;
      last_in      = last_ff;
      d_idle_in    = d_idle_ff;
      d_el_in      = d_el_ff;
      busy_in      = busy_ff;
      dzero_in     = dzero_ff;
      round_max_in = round_max_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_peak_in  = rsp_peak_ff;
      rsp_cap_in   = rsp_cap_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_ceil_in  = rsp_ceil_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && enable_ff) begin
               cur_idle_in = hist_wdata.idle;
               cur_el_in   = hist_wdata.elapsed;
               last_in     = req_tlast;
               if (core_valid) begin
                  state_in = ST_READ;
               end else if (req_tlast) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            d_idle_in = cur_idle_ff - hist_rdata.idle;
            d_el_in   = cur_el_ff - hist_rdata.elapsed;
            state_in  = ST_DELTA;
         end
         ST_DELTA: begin
            busy_in  = busy_diff[DW] ? '0 : busy_diff[DW-1:0];
            dzero_in = (d_el_ff == '0);
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if (core_load > round_max_ff) begin
                  round_max_in = core_load;
               end
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_peak_in  = round_max_ff;
               rsp_cap_in   = new_limit;
               rsp_chg_in   = (new_limit != limit_ff);
               rsp_ceil_in  = new_limit ? cap_freq_ff : '0;
               limit_in     = new_limit;
               round_max_in = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_max_ff <= '0;
         limit_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_max_ff <= round_max_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_idle_ff <= cur_idle_in;
      cur_el_ff   <= cur_el_in;
      last_ff     <= last_in;
      d_idle_ff   <= d_idle_in;
      d_el_ff     <= d_el_in;
      busy_ff     <= busy_in;
      dzero_ff    <= dzero_in;
      rsp_peak_ff <= rsp_peak_in;
      rsp_cap_ff  <= rsp_cap_in;
      rsp_chg_ff  <= rsp_chg_in;
      rsp_ceil_ff <= rsp_ceil_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         threshold_ff <= lbfc_pkg::THRESHOLD_RESET;
         cap_freq_ff  <= lbfc_pkg::CAP_FREQ_RESET;
      end else if (csr_we) begin
         unique case (lbfc_pkg::csr_index_type'(csr_index))
            lbfc_pkg::CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            lbfc_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata[LW-1:0];
            lbfc_pkg::CSR_CAP_FREQ:  cap_freq_ff  <= csr_wdata[FW-1:0];
            default: begin
            end
         endcase
      end
   end

   // response outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ceil_ff, rsp_chg_ff, rsp_cap_ff, rsp_peak_ff};

endmodule

`default_nettype wire

/* hdl/lbfc_checker.sv */
// lbfc_checker: port-level assertions for load_based_frequency_cap_core
// bound to the top level below; watches only its ports
`default_nettype none

module lbfc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // no response pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // peak load is a percentage
   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:0] <= 7'd100)
      else $error("peak load above 100");

   // ceiling is zero whenever the cap is not active
   a_ceiling_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[7] |-> rsp_tdata[30:9] == 22'd0)
      else $error("ceiling reported without cap");

endmodule

bind load_based_frequency_cap_core lbfc_checker u_lbfc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* test/load_based_frequency_cap_core_tb.sv */
// load_based_frequency_cap_core_tb: self-checking bench for the load based cap core
// directed table then random poll rounds, checked against table results or an in-bench predictor
// depends on lbfc_pkg and load_based_frequency_cap_core
module load_based_frequency_cap_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CORES       = 4;
   localparam int SETTLE      = 24;      // settle wait that lets a request still in flight finish
   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 300000;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // one response: peak_load in the low bits, ceiling_khz on top
   typedef struct packed {
      logic [lbfc_pkg::FREQ_W-1:0] ceiling;
      logic                        changed;
      logic                        active;
      logic [lbfc_pkg::LOAD_W-1:0] peak;
   } cap_result_type;

   typedef struct {
      row_kind_type            kind;
      logic [1:0]              core;
      logic [63:0]             idle;
      logic [63:0]             elapsed;
      logic                    last;
      bit                      typed;
      cap_result_type          result;
      lbfc_pkg::csr_index_type reg_index;
      logic [21:0]             reg_value;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;   // idle_time [63:0], elapsed_time [127:64]
   logic [1:0]    req_tuser = '0;   // core_index [1:0]
   logic          req_tlast = 1'b0; // last_core
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;        // peak_load [6:0], cap_active [7], cap_changed [8],
                                    // ceiling_khz [30:9], zero [31]
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = lbfc_pkg::CSR_ENABLE;
   logic [21:0]   csr_wdata = '0;

   // predictor state and register copies
   logic [63:0]                 last_idle [CORES];
   logic [63:0]                 last_elapsed [CORES];
   logic [lbfc_pkg::LOAD_W-1:0] peak_so_far;
   logic                        cap_was_active;
   logic                        cfg_enable;
   logic [lbfc_pkg::LOAD_W-1:0] cfg_threshold;
   logic [lbfc_pkg::FREQ_W-1:0] cfg_cap_khz;

   cap_result_type expected_caps [$];
   stim_row_type   directed_rows [$];

   // running counters used to build well-formed samples
   logic [63:0] gen_idle [CORES];
   logic [63:0] gen_elapsed [CORES];

   int  errors = 0;
   int  results_seen = 0;
   int  cycles = 0;
   bit  gaps_on = 1'b1;
   bit  quiet = 1'b0;
   bit  hold_done = 1'b0;

   load_based_frequency_cap_core #(
      .NUM_CORES(CORES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // load of one sample, peak tracking and the round decision
   function automatic bit predict_sample(input logic [1:0] core, input logic [63:0] idle,
                                         input logic [63:0] elapsed, input logic last,
                                         output cap_result_type res);
      logic [63:0]                 diff_idle;
      logic [63:0]                 diff_el;
      logic [31:0]                 busy;
      logic [63:0]                 scaled;
      logic [lbfc_pkg::LOAD_W-1:0] load;
      logic                        now_active;
      res = '0;
      if (!cfg_enable) return 1'b0;
      diff_idle = idle - last_idle[core];
      diff_el   = elapsed - last_elapsed[core];
      last_idle[core]    = idle;
      last_elapsed[core] = elapsed;
      // zero elapsed, or idle at or over elapsed, both give no load
      busy = (diff_el[31:0] > diff_idle[31:0]) ? diff_el[31:0] - diff_idle[31:0] : 32'd0;
      scaled = {32'd0, busy} * 64'd100;
      if (diff_el[31:0] == 32'd0)
         load = '0;
      else
         load = lbfc_pkg::LOAD_W'(scaled / {32'd0, diff_el[31:0]});
      if (load > peak_so_far) peak_so_far = load;
      if (!last) return 1'b0;
      now_active     = (peak_so_far <= cfg_threshold);
      res.peak       = peak_so_far;
      res.active     = now_active;
      res.changed    = (now_active != cap_was_active);
      res.ceiling    = now_active ? cfg_cap_khz : '0;
      cap_was_active = now_active;
      peak_so_far    = '0;
      return 1'b1;
   endfunction

   function automatic stim_row_type req_row(input logic [1:0] core, input logic [63:0] idle,
                                            input logic [63:0] elapsed, input logic last);
      stim_row_type r;
      r = '{kind: ROW_REQ, core: core, idle: idle, elapsed: elapsed, last: last,
            typed: 1'b0, result: '0, reg_index: lbfc_pkg::CSR_ENABLE, reg_value: '0};
      return r;
   endfunction

   function automatic stim_row_type known_row(input logic [1:0] core, input logic [63:0] idle,
                                              input logic [63:0] elapsed,
                                              input logic [6:0] peak, input logic active,
                                              input logic changed, input logic [21:0] ceiling);
      stim_row_type r;
      r = req_row(core, idle, elapsed, 1'b1);
      r.typed  = 1'b1;
      r.result = '{ceiling: ceiling, changed: changed, active: active, peak: peak};
      return r;
   endfunction

   function automatic stim_row_type csr_row(input lbfc_pkg::csr_index_type idx,
                                            input logic [21:0] value);
      stim_row_type r;
      r = req_row(2'd0, 64'd0, 64'd0, 1'b0);
      r.kind      = ROW_CSR;
      r.reg_index = idx;
      r.reg_value = value;
      return r;
   endfunction

   // offer one request, wait for the handshake, then record what it should produce
   task automatic offer_request(input logic [1:0] core, input logic [63:0] idle,
                                input logic [63:0] elapsed, input logic last,
                                input bit typed, input cap_result_type known);
      int             gap;
      cap_result_type predicted;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {elapsed, idle};
      req_tuser  <= core;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (predict_sample(core, idle, elapsed, last, predicted))
         expected_caps.push_back(typed ? known : predicted);
   endtask

   // sender stops until every response is back and the block has settled
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (expected_caps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input lbfc_pkg::csr_index_type idx, input logic [21:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         lbfc_pkg::CSR_ENABLE:    cfg_enable    = value[0];
         lbfc_pkg::CSR_THRESHOLD: cfg_threshold = value[lbfc_pkg::LOAD_W-1:0];
         lbfc_pkg::CSR_CAP_FREQ:  cfg_cap_khz   = value[lbfc_pkg::FREQ_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // next sample of one core: mostly steady counters, some wraps, jumps and odd deltas
   task automatic make_sample(input logic [1:0] core, output logic [63:0] idle,
                              output logic [63:0] elapsed);
      int          mode;
      logic [31:0] d_el;
      logic [31:0] d_idle;
      logic [63:0] busy;
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
         gen_idle[core]    = {$urandom, $urandom};
         gen_elapsed[core] = {$urandom, $urandom};
      end else begin
         if (mode == 1) begin
            d_el   = 32'd0;
            d_idle = $urandom_range(0, 1000);
         end else if (mode == 2) begin
            d_el   = $urandom_range(1, 1000);
            d_idle = d_el + $urandom_range(0, 1000);
         end else begin
            d_el   = (mode < 8) ? $urandom : $urandom_range(1, 100000);
            busy   = ({32'd0, d_el} * $urandom_range(0, 100)) / 64'd100;
            d_idle = d_el - busy[31:0];
         end
         gen_idle[core]    = gen_idle[core] + {32'd0, d_idle};
         gen_elapsed[core] = gen_elapsed[core] + {32'd0, d_el};
         // move the upper halves now and then; the deltas stay the same
         if ($urandom_range(0, 3) == 0) begin
            gen_idle[core]    = gen_idle[core] + {$urandom, 32'd0};
            gen_elapsed[core] = gen_elapsed[core] + {$urandom, 32'd0};
         end
      end
      idle    = gen_idle[core];
      elapsed = gen_elapsed[core];
   endtask

   // poll rounds of random length over random cores, with a little noise on tlast
   task automatic run_rounds(input int n_items);
      int          done;
      int          len;
      logic [1:0]  core;
      logic [63:0] idle;
      logic [63:0] elapsed;
      logic        last;
      done = 0;
      while (done < n_items) begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            core = 2'($urandom_range(0, CORES - 1));
            make_sample(core, idle, elapsed);
            last = (i == len - 1);
            if ($urandom_range(0, 14) == 0) last = 1'($urandom_range(0, 1));
            offer_request(core, idle, elapsed, last, 1'b0, '0);
            done++;
         end
         if ($urandom_range(0, 24) == 0) wait_for_quiet();
      end
   endtask

   // response side: random stalls, one long hold-off, none at the end
   initial begin
      forever begin
         @(posedge clock);
         if (!hold_done && results_seen >= 30) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // response check against the oldest expectation
   always @(posedge clock) begin
      cap_result_type want;
      cap_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got = cap_result_type'(rsp_tdata[30:0]);
         if (expected_caps.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_caps.pop_front();
            if (got.peak != want.peak) begin
               $error("peak_load: expected %0d, got %0d", want.peak, got.peak);
               errors++;
            end
            if (got.active != want.active) begin
               $error("cap_active: expected %0d, got %0d", want.active, got.active);
               errors++;
            end
            if (got.changed != want.changed) begin
               $error("cap_changed: expected %0d, got %0d", want.changed, got.changed);
               errors++;
            end
            if (got.ceiling != want.ceiling) begin
               $error("ceiling_khz: expected %0d, got %0d", want.ceiling, got.ceiling);
               errors++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [21:0] value;
      for (int c = 0; c < CORES; c++) begin
         last_idle[c]    = '0;
         last_elapsed[c] = '0;
         gen_idle[c]     = {$urandom, $urandom};
         gen_elapsed[c]  = {$urandom, $urandom};
      end
      peak_so_far    = '0;
      cap_was_active = 1'b0;
      cfg_enable     = 1'b1;
      cfg_threshold  = lbfc_pkg::THRESHOLD_RESET;
      cfg_cap_khz    = lbfc_pkg::CAP_FREQ_RESET;

      // directed table: reset values first, then edges of every field and register
      directed_rows.push_back(known_row(2'd0, 64'd0, 64'd0, 7'd0, 1'b1, 1'b1, 22'd1300000));
      directed_rows.push_back(known_row(2'd0, 64'd0, 64'd1000, 7'd100, 1'b0, 1'b1, 22'd0));
      directed_rows.push_back(req_row(2'd1, 64'd500, 64'd200, 1'b0));
      directed_rows.push_back(req_row(2'd2, 64'd0, 64'hFFFF_FFFF, 1'b0));
      directed_rows.push_back(known_row(2'd3, '1, '1, 7'd100, 1'b0, 1'b0, 22'd0));
      directed_rows.push_back(req_row(2'd0, 64'hFFFF_FFFF_0000_0000,
                                      64'h1234_5678_0000_1000, 1'b0));
      directed_rows.push_back(req_row(2'd1, 64'd550, 64'd300, 1'b1));
      directed_rows.push_back(req_row(2'd1, 64'd600, 64'd400, 1'b1));
      directed_rows.push_back(csr_row(lbfc_pkg::CSR_THRESHOLD, 22'd0));
      directed_rows.push_back(req_row(2'd2, 64'd5, 64'hFFFF_FFFF, 1'b1));
      directed_rows.push_back(req_row(2'd3, '1, 64'd0, 1'b1));
      directed_rows.push_back(csr_row(lbfc_pkg::CSR_THRESHOLD, 22'd100));
      directed_rows.push_back(req_row(2'd0, 64'hFFFF_FFFF_0000_0000,
                                      64'h1234_5678_0000_10C8, 1'b1));
      directed_rows.push_back(csr_row(lbfc_pkg::CSR_THRESHOLD, 22'd127));
      directed_rows.push_back(csr_row(lbfc_pkg::CSR_CAP_FREQ, 22'h3F_FFFF));
      directed_rows.push_back(req_row(2'd0, 64'hFFFF_FFFF_0000_0000,
                                      64'h1234_5678_0000_10FA, 1'b1));
      directed_rows.push_back(csr_row(lbfc_pkg::CSR_CAP_FREQ, 22'd0));
      directed_rows.push_back(req_row(2'd1, 64'd600, 64'd400, 1'b1));
      // disabled: requests are dropped and leave no trace
      directed_rows.push_back(csr_row(lbfc_pkg::CSR_ENABLE, 22'd0));
      directed_rows.push_back(req_row(2'd2, 64'd0, 64'd1000, 1'b1));
      directed_rows.push_back(req_row(2'd3, 64'hDEAD_BEEF_0123_4567, '1, 1'b0));
      directed_rows.push_back(csr_row(lbfc_pkg::CSR_ENABLE, 22'd1));
      directed_rows.push_back(csr_row(lbfc_pkg::CSR_THRESHOLD, 22'd90));
      directed_rows.push_back(csr_row(lbfc_pkg::CSR_CAP_FREQ, 22'd1300000));
      directed_rows.push_back(req_row(2'd2, 64'd5, 64'h1_0000_0063, 1'b0));
      directed_rows.push_back(req_row(2'd2, 64'd35, 64'h1_0000_00C7, 1'b1));
      directed_rows.push_back(req_row(2'd1, 64'd610, 64'd420, 1'b1));
      // counter wrap on core 3, peak exactly at threshold, then one above
      directed_rows.push_back(req_row(2'd3, 64'd0, 64'd10, 1'b1));
      directed_rows.push_back(req_row(2'd3, 64'd9, 64'd110, 1'b1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_for_quiet();
            write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            offer_request(directed_rows[i].core, directed_rows[i].idle,
                          directed_rows[i].elapsed, directed_rows[i].last,
                          directed_rows[i].typed, directed_rows[i].result);
         end
      end

      // random phases, each under its own register setting
      for (int p = 0; p < 6; p++) begin
         wait_for_quiet();
         write_register(lbfc_pkg::CSR_ENABLE, (p == 2) ? 22'd0 : 22'd1);
         case ($urandom_range(0, 4))
            0:       value = 22'd0;
            1:       value = 22'd100;
            2:       value = 22'd127;
            3:       value = 22'($urandom_range(0, 127));
            default: value = 22'($urandom_range(80, 100));
         endcase
         write_register(lbfc_pkg::CSR_THRESHOLD, value);
         case ($urandom_range(0, 3))
            0:       value = 22'd0;
            1:       value = 22'h3F_FFFF;
            default: value = 22'($urandom);
         endcase
         write_register(lbfc_pkg::CSR_CAP_FREQ, value);
         if (p == 5) begin
            gaps_on = 1'b0;
            quiet   = 1'b1;
         end
         run_rounds((p == 2) ? 30 : 136);
      end

      wait_for_quiet();
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
